[design/blzd_pkg.sv]
package blzd_pkg;

  localparam int HISTORY_DEPTH = 8192;
  localparam int HIST_AW = $clog2(HISTORY_DEPTH);

  localparam logic [HIST_AW:0]   HIST_DEPTH_W = (HIST_AW + 1)'(HISTORY_DEPTH);
  localparam logic [HIST_AW-1:0] HIST_LAST    = HIST_AW'(HISTORY_DEPTH - 1);

  localparam logic [4:0]  LEN_BIAS   = 5'd3;
  localparam logic [12:0] DIST_BIAS  = 13'd2;
  localparam logic [3:0]  FLAG_COUNT = 4'd8;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [31:0] out_address;
    logic        format_error;
    logic        run_last;
    logic        stream_done;
  } result_t;

  // step a history pointer down by one, wrapping at the bottom
  function automatic logic [HIST_AW-1:0] hist_dec(input logic [HIST_AW-1:0] a);
    logic [HIST_AW-1:0] r;
    if (a == '0) begin
      r = HIST_LAST;
    end else begin
      r = a - 1'b1;
    end
    return r;
  endfunction

endpackage

[design/blzd_cfg_if.sv]
interface blzd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] output_space;

  modport source(output valid, output output_space, input ready);
  modport sink(input valid, input output_space, output ready);
endinterface

[design/blzd_in_if.sv]
interface blzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       region_last;

  modport source(output valid, output data_byte, output region_last, input ready);
  modport sink(input valid, input data_byte, input region_last, output ready);
endinterface

[design/blzd_out_if.sv]
interface blzd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [31:0] out_address;
  logic        format_error;
  logic        run_last;
  logic        stream_done;

  modport source(output valid, output out_byte, output out_address, output format_error,
                 output run_last, output stream_done, input ready);
  modport sink(input valid, input out_byte, input out_address, input format_error,
               input run_last, input stream_done, output ready);
endinterface

[design/blzd_ram.sv]
module blzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/blzd_out_stage.sv]
module blzd_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  blzd_pkg::result_t  d,
  output logic               free,
  blzd_out_if.source         dst
);

  logic              valid;
  blzd_pkg::result_t data;

  assign free = !valid || dst.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (dst.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= d;
    end
  end

  assign dst.valid        = valid;
  assign dst.out_byte     = data.out_byte;
  assign dst.out_address  = data.out_address;
  assign dst.format_error = data.format_error;
  assign dst.run_last     = data.run_last;
  assign dst.stream_done  = data.stream_done;

endmodule

[design/backward_lzss_decompressor_core.sv]
// Backward LZSS decompressor. Compressed bytes enter on src one item at a time, from
// the end of the region toward its start; decompressed bytes leave on dst with their
// output buffer position, counting down from output_space. Writing output_space on cfg
// starts a new stream. A control byte, a pair high byte or a literal is accepted and
// then decoded; a back-reference is accepted, decoded and then copies its 3 to 18 bytes
// one by one, each read from and written back to the single history memory in turn.
// dst can stall the decode and each copied byte; src takes no new item until the last
// is finished. Errors are sticky until the next cfg write, and once the stream is done
// further items are accepted and dropped. History memory needs no clearing after reset.
module backward_lzss_decompressor_core (
  input  logic        clk,
  input  logic        rst,
  blzd_cfg_if.sink    cfg,
  blzd_in_if.sink     src,
  blzd_out_if.source  dst
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;

  localparam int AW = blzd_pkg::HIST_AW;

  logic [1:0]    state, state_next;
  logic [31:0]   output_space, output_space_next;
  logic [31:0]   write_pos, write_pos_next;
  logic [7:0]    flag_bits, flag_bits_next;
  logic [3:0]    flags_left, flags_left_next;
  logic          pair_phase, pair_phase_next;
  logic [7:0]    pair_high, pair_high_next;
  logic          error_seen, error_seen_next;
  logic          region_ended, region_ended_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [AW-1:0] src_ptr, src_ptr_next;
  logic [4:0]    copy_cnt, copy_cnt_next;
  logic [7:0]    hold_byte;
  logic          hold_last;

  logic          done_now;
  logic [4:0]    len;
  logic [12:0]   distance;
  logic          too_long;
  logic          too_far;
  logic [AW:0]   src_sum;
  logic [AW-1:0] src_start;
  logic [AW-1:0] ptr_dec;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic              out_free;
  logic              out_load;
  blzd_pkg::result_t out_d;

  assign src.ready = (state == ST_IDLE);
  assign cfg.ready = (state == ST_IDLE);

  assign done_now  = error_seen || region_ended || (write_pos == 32'd0);
  assign len       = 5'(pair_high[7:4]) + blzd_pkg::LEN_BIAS;
  assign distance  = {pair_high[3:0], hold_byte} + blzd_pkg::DIST_BIAS;
  assign too_long  = write_pos < 32'(len);
  assign too_far   = ({1'b0, write_pos} + 33'(distance)) >= {1'b0, output_space};
  assign src_sum   = {1'b0, ptr} + (AW + 1)'(distance);
  assign src_start = (src_sum >= blzd_pkg::HIST_DEPTH_W) ?
                     AW'(src_sum - blzd_pkg::HIST_DEPTH_W) : src_sum[AW-1:0];
  assign ptr_dec   = blzd_pkg::hist_dec(ptr);

  always_comb begin
    state_next        = state;
    output_space_next = output_space;
    write_pos_next    = write_pos;
    flag_bits_next    = flag_bits;
    flags_left_next   = flags_left;
    pair_phase_next   = pair_phase;
    pair_high_next    = pair_high;
    error_seen_next   = error_seen;
    region_ended_next = region_ended;
    ptr_next          = ptr;
    src_ptr_next      = src_ptr;
    copy_cnt_next     = copy_cnt;

    ram_we    = 1'b0;
    ram_waddr = ptr_dec;
    ram_wdata = hold_byte;
    ram_re    = 1'b0;
    ram_raddr = src_ptr;
    out_load  = 1'b0;
    out_d     = '{out_byte: 8'h00, out_address: write_pos, format_error: 1'b0,
                  run_last: 1'b1, stream_done: 1'b0};

    case (state)
      ST_IDLE: begin
        if (src.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done_now) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          state_next = ST_IDLE;
          if (hold_last) begin
            region_ended_next = 1'b1;
          end
          if (pair_phase) begin
            pair_phase_next = 1'b0;
            if (too_long || too_far) begin
              out_load           = 1'b1;
              out_d.format_error = 1'b1;
              out_d.stream_done  = 1'b1;
              error_seen_next    = 1'b1;
            end else begin
              ram_re        = 1'b1;
              ram_raddr     = src_start;
              src_ptr_next  = blzd_pkg::hist_dec(src_start);
              copy_cnt_next = len;
              state_next    = ST_COPY;
            end
          end else if (flags_left == 4'd0) begin
            flag_bits_next  = hold_byte;
            flags_left_next = blzd_pkg::FLAG_COUNT;
          end else begin
            flag_bits_next  = {flag_bits[6:0], 1'b0};
            flags_left_next = flags_left - 4'd1;
            if (flag_bits[7]) begin
              pair_high_next  = hold_byte;
              pair_phase_next = 1'b1;
              if (hold_last) begin
                out_load           = 1'b1;
                out_d.format_error = 1'b1;
                out_d.stream_done  = 1'b1;
                error_seen_next    = 1'b1;
              end
            end else begin
              // literal
              ram_we            = 1'b1;
              ptr_next          = ptr_dec;
              write_pos_next    = write_pos - 32'd1;
              out_load          = 1'b1;
              out_d.out_byte    = hold_byte;
              out_d.out_address = write_pos - 32'd1;
              out_d.stream_done = hold_last || (write_pos == 32'd1);
            end
          end
        end
      end
      ST_COPY: begin
        if (out_free) begin
          ram_we            = 1'b1;
          ram_wdata         = ram_rdata;
          ptr_next          = ptr_dec;
          write_pos_next    = write_pos - 32'd1;
          copy_cnt_next     = copy_cnt - 5'd1;
          out_load          = 1'b1;
          out_d.out_byte    = ram_rdata;
          out_d.out_address = write_pos - 32'd1;
          out_d.run_last    = (copy_cnt == 5'd1);
          out_d.stream_done = (copy_cnt == 5'd1) && (hold_last || (write_pos == 32'd1));
          if (copy_cnt == 5'd1) begin
            state_next = ST_IDLE;
          end else begin
            // source is always at least two bytes above the write point
            ram_re       = 1'b1;
            ram_raddr    = src_ptr;
            src_ptr_next = blzd_pkg::hist_dec(src_ptr);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cfg.valid && cfg.ready) begin
      output_space_next = cfg.output_space;
      write_pos_next    = cfg.output_space;
      flag_bits_next    = 8'h00;
      flags_left_next   = 4'd0;
      pair_phase_next   = 1'b0;
      pair_high_next    = 8'h00;
      error_seen_next   = 1'b0;
      region_ended_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      output_space <= 32'd0;
      write_pos    <= 32'd0;
      flag_bits    <= 8'h00;
      flags_left   <= 4'd0;
      pair_phase   <= 1'b0;
      pair_high    <= 8'h00;
      error_seen   <= 1'b0;
      region_ended <= 1'b0;
      ptr          <= '0;
      src_ptr      <= '0;
      copy_cnt     <= 5'd0;
    end else begin
      state        <= state_next;
      output_space <= output_space_next;
      write_pos    <= write_pos_next;
      flag_bits    <= flag_bits_next;
      flags_left   <= flags_left_next;
      pair_phase   <= pair_phase_next;
      pair_high    <= pair_high_next;
      error_seen   <= error_seen_next;
      region_ended <= region_ended_next;
      ptr          <= ptr_next;
      src_ptr      <= src_ptr_next;
      copy_cnt     <= copy_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      hold_byte <= src.data_byte;
      hold_last <= src.region_last;
    end
  end

  blzd_ram #(
    .WIDTH (8),
    .DEPTH (blzd_pkg::HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  blzd_out_stage u_out (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .d    (out_d),
    .free (out_free),
    .dst  (dst)
  );

endmodule

[tb/sv/backward_lzss_decompressor_core_tb.sv]
`timescale 1ns / 100ps

module backward_lzss_decompressor_core_tb;

  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 270;
  localparam int QUIET_ITEMS   = 50;
  localparam int MAX_LEN       = 18;
  localparam int MAX_DIST      = 4097;

  class decode_scoreboard;
    logic [7:0]        hist [blzd_pkg::HISTORY_DEPTH];
    logic [31:0]       space;
    logic [31:0]       wpos;
    logic [7:0]        flags;
    logic [3:0]        flags_left;
    logic              in_pair;
    logic [7:0]        pair_hi;
    logic              err_seen;
    logic              ended;
    blzd_pkg::result_t expected_bytes[$];
    int                mismatches;

    function new();
      foreach (hist[i]) hist[i] = 8'h00;
      mismatches = 0;
      set_space(32'd0);
    endfunction

    function void set_space(logic [31:0] v);
      space      = v;
      wpos       = v;
      flags      = 8'h00;
      flags_left = 4'd0;
      in_pair    = 1'b0;
      pair_hi    = 8'h00;
      err_seen   = 1'b0;
      ended      = 1'b0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function logic finished();
      return err_seen || ended || (wpos == 32'd0);
    endfunction

    function void put_byte(logic [7:0] b);
      blzd_pkg::result_t r;
      wpos = wpos - 32'd1;
      hist[wpos % blzd_pkg::HISTORY_DEPTH] = b;
      r = '{out_byte: b, out_address: wpos, format_error: 1'b0, run_last: 1'b0,
            stream_done: 1'b0};
      expected_bytes.push_back(r);
    endfunction

    function void put_error();
      blzd_pkg::result_t r;
      err_seen = 1'b1;
      r = '{out_byte: 8'h00, out_address: wpos, format_error: 1'b1, run_last: 1'b0,
            stream_done: 1'b0};
      expected_bytes.push_back(r);
    endfunction

    function void take_compressed(logic [7:0] b, logic last);
      int                first;
      logic [31:0]       len;
      logic [31:0]       distance;
      logic              is_ref;
      blzd_pkg::result_t tail;
      first = expected_bytes.size();
      if (finished()) return;
      if (in_pair) begin
        len      = 32'(pair_hi[7:4]) + 32'(blzd_pkg::LEN_BIAS);
        distance = 32'({pair_hi[3:0], b}) + 32'(blzd_pkg::DIST_BIAS);
        in_pair  = 1'b0;
        if (wpos < len) begin
          put_error();
        end else if ({1'b0, wpos} + {1'b0, distance} >= {1'b0, space}) begin
          put_error();
        end else begin
          for (int j = 0; j < len; j++) begin
            put_byte(hist[(wpos + distance) % blzd_pkg::HISTORY_DEPTH]);
          end
        end
      end else if (flags_left == 4'd0) begin
        flags      = b;
        flags_left = blzd_pkg::FLAG_COUNT;
      end else begin
        is_ref     = flags[7];
        flags      = flags << 1;
        flags_left = flags_left - 4'd1;
        if (is_ref) begin
          pair_hi = b;
          in_pair = 1'b1;
          if (last) put_error();
        end else begin
          put_byte(b);
        end
      end
      if (last) ended = 1'b1;
      if (expected_bytes.size() > first) begin
        tail             = expected_bytes[$];
        tail.run_last    = 1'b1;
        tail.stream_done = finished();
        expected_bytes[$] = tail;
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_output(blzd_pkg::result_t got);
      blzd_pkg::result_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected item at address %h", got.out_address));
      end else begin
        want = expected_bytes.pop_front();
        check_field("out_byte", 32'(got.out_byte), 32'(want.out_byte));
        check_field("out_address", got.out_address, want.out_address);
        check_field("format_error", 32'(got.format_error), 32'(want.format_error));
        check_field("run_last", 32'(got.run_last), 32'(want.run_last));
        check_field("stream_done", 32'(got.stream_done), 32'(want.stream_done));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic quiet;
  int   sink_left;
  logic [7:0] comp_bytes[$];
  decode_scoreboard sb;

  blzd_cfg_if cfg();
  blzd_in_if  src();
  blzd_out_if dst();

  backward_lzss_decompressor_core uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .src (src),
    .dst (dst)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      dst.ready <= 1'b0;
      sink_left <= 0;
    end else if (quiet) begin
      dst.ready <= 1'b1;
    end else if (sink_left != 0) begin
      sink_left <= sink_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      dst.ready <= 1'b0;
      sink_left <= $urandom_range(0, 7);
    end else begin
      dst.ready <= 1'b1;
      sink_left <= $urandom_range(0, 24);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (dst.valid && dst.ready) begin
        sb.check_output(blzd_pkg::result_t'({dst.out_byte, dst.out_address,
                                             dst.format_error, dst.run_last,
                                             dst.stream_done}));
      end
      if (src.valid && src.ready) sb.take_compressed(src.data_byte, src.region_last);
      if (cfg.valid && cfg.ready) sb.set_space(cfg.output_space);
    end
  end

  task settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task start_stream(logic [31:0] space);
    settle();
    cfg.valid        <= 1'b1;
    cfg.output_space <= space;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  task send_item(logic [7:0] b, logic last);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      src.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src.valid       <= 1'b1;
    src.data_byte   <= b;
    src.region_last <= last;
    @(posedge clk);
    while (!src.ready) @(posedge clk);
  endtask

  task play(int pause_at, int extra);
    for (int i = 0; i < comp_bytes.size(); i++) begin
      if (i == pause_at) begin
        src.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      send_item(comp_bytes[i], i == comp_bytes.size() - 1);
    end
    repeat (extra) send_item(8'($urandom), 1'($urandom));
    src.valid <= 1'b0;
  endtask

  // mostly well-formed groups, with an occasional random pair as noise
  task build_stream(logic [31:0] space, int n, int bad_pct);
    longint     room;
    longint     written;
    longint     len;
    longint     distance;
    int         roll;
    logic [7:0] ctl;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] body[$];
    room = longint'(space);
    comp_bytes.delete();
    while (comp_bytes.size() < n) begin
      ctl = 8'h00;
      body.delete();
      for (int i = 0; i < 8; i++) begin
        written = longint'(space) - room;
        roll    = $urandom_range(0, 99);
        if (roll < bad_pct) begin
          ctl[7-i] = 1'b1;
          hi       = 8'($urandom);
          lo       = 8'($urandom);
          len      = longint'(hi[7:4]) + 3;
          distance = longint'({hi[3:0], lo}) + 2;
          if (room >= len && room + distance < longint'(space)) room -= len;
          body.push_back(hi);
          body.push_back(lo);
        end else if (room >= 3 && written >= 3 && roll < bad_pct + 40) begin
          ctl[7-i] = 1'b1;
          len      = $urandom_range(3, (room < MAX_LEN) ? int'(room) : MAX_LEN);
          distance = $urandom_range(2, (written - 1 < MAX_DIST) ? int'(written - 1)
                                                                 : MAX_DIST);
          room -= len;
          body.push_back({4'(len - 3), 4'((distance - 2) >> 8)});
          body.push_back(8'(distance - 2));
        end else begin
          body.push_back(8'($urandom));
          if (room > 0) room--;
        end
      end
      comp_bytes.push_back(ctl);
      foreach (body[i]) comp_bytes.push_back(body[i]);
    end
    while (comp_bytes.size() > n) void'(comp_bytes.pop_back());
  endtask

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int          total;
    int          n;
    int          k;
    int          pick;
    logic [31:0] space;
    sb = new();
    clk              = 1'b0;
    quiet            = 1'b0;
    rst             <= 1'b1;
    cfg.valid       <= 1'b0;
    cfg.output_space <= 32'd0;
    src.valid       <= 1'b0;
    src.data_byte   <= 8'h00;
    src.region_last <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // zero space drops everything
    start_stream(32'd0);
    comp_bytes = '{8'h00, 8'hFF};
    play(-1, 0);

    // literals, shortest and longest copy, overlapping source
    start_stream(32'd40);
    comp_bytes = '{8'h18, 8'h00, 8'hFF, 8'hA5, 8'h00, 8'h00, 8'hF0, 8'h03,
                   8'h5A, 8'h81, 8'h7E};
    play(-1, 0);

    // distance past the written bytes, then dropped input
    start_stream(32'hFFFF_FFFF);
    comp_bytes = '{8'hC0, 8'h0F, 8'hFF};
    play(-1, 1);

    // copy longer than the space left
    start_stream(32'd4);
    comp_bytes = '{8'h10, 8'h11, 8'h22, 8'h33, 8'h00, 8'h00};
    play(-1, 0);

    // output full, then dropped input
    start_stream(32'd1);
    comp_bytes = '{8'h00, 8'hFF};
    play(-1, 1);

    // region ends on the high byte of a pair
    start_stream(32'd10);
    comp_bytes = '{8'h80, 8'h37};
    play(-1, 0);

    total = 0;
    k     = 0;
    while (total < RANDOM_ITEMS) begin
      quiet = (total >= RANDOM_ITEMS - QUIET_ITEMS);
      pick  = $urandom_range(0, 9);
      case (pick)
        0: begin
          space = 32'hFFFF_FFFF;
        end
        1: begin
          space = 32'(blzd_pkg::HISTORY_DEPTH) + $urandom_range(0, 40);
        end
        2: begin
          space = $urandom_range(1, 20);
        end
        default: begin
          space = $urandom_range(30, 400);
        end
      endcase
      n = $urandom_range(12, 40);
      start_stream(space);
      build_stream(space, n, ($urandom_range(0, 3) == 0) ? 8 : 1);
      if (k == 0) begin
        play(n / 2, 0);
      end else begin
        play(($urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : -1,
             $urandom_range(0, 2));
      end
      total += n;
      k++;
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
